### src/assert_macros.svh
// Assertion macros shared by the median filter RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RMF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rmf assertion failed");
`define RMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmf assertion failed");
`else
`define RMF_ASSERT(label, clk, rst, prop)
`define RMF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/rmf_pkg.sv
// Package for the RGB 3x3 median filter: sizes, payload and control types.
// Depends on nothing.
`default_nettype none
package rmf_pkg;
   localparam int WINDOW_SIDE = 3;
   localparam int AREA        = WINDOW_SIDE * WINDOW_SIDE;
   localparam int PIX_W       = 8;
   localparam int COUNT_W     = 12;
   localparam int FILL_W      = 4;
   localparam int ROW_W       = 2;
   localparam logic [COUNT_W-1:0] WIDTH_RESET = 12'd512;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_red;
      logic [PIX_W-1:0] pixel_green;
      logic [PIX_W-1:0] pixel_blue;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] median_red;
      logic [PIX_W-1:0] median_green;
      logic [PIX_W-1:0] median_blue;
   } rsp_payload_type;

   typedef logic [AREA-1:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;
endpackage
`default_nettype wire

### src/rmf_tap_cell.sv
// One window tap: holds one RGB pixel, loads it directly or takes it
// from its right-hand neighbor. Depends on rmf_pkg.
`default_nettype none
module rmf_tap_cell (
   input  wire logic                     clock,
   input  wire rmf_pkg::cell_ctl_type    ctl,
   input  wire rmf_pkg::req_payload_type pixel_in,
   input  wire rmf_pkg::req_payload_type neighbor_in,
   output rmf_pkg::req_payload_type      tap_out,
   output rmf_pkg::req_payload_type      tap_next
);
   rmf_pkg::req_payload_type tap_ff;
   rmf_pkg::req_payload_type tap_in;

   always_comb begin
      priority if (ctl.load) begin
         tap_in = pixel_in;
      end else if (ctl.shift) begin
         tap_in = neighbor_in;
      end else begin
         tap_in = tap_ff;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff <= tap_in;
   end

   assign tap_out  = tap_ff;
   assign tap_next = tap_in;
endmodule
`default_nettype wire

### src/rmf_median_lane.sv
// Four-stage median-of-nine datapath for one color channel.
// Depends on rmf_pkg; stage enables come from the top-level control.
`default_nettype none
module rmf_median_lane (
   input  wire logic                               clock,
   input  wire rmf_pkg::stage_en_type              en,
   input  wire rmf_pkg::window_type                window_in,
   output logic [rmf_pkg::PIX_W-1:0]               median_out
);
   localparam int W = rmf_pkg::PIX_W;
   localparam int S = rmf_pkg::WINDOW_SIDE;

   function automatic logic [2:0][W-1:0] sort3(input logic [W-1:0] a,
                                               input logic [W-1:0] b,
                                               input logic [W-1:0] c);
      logic [W-1:0] x;
      logic [W-1:0] y;
      logic [W-1:0] z;
      logic [W-1:0] t;
      x = a;
      y = b;
      z = c;
      if (y > z) begin
         t = y; y = z; z = t;
      end
      if (x > y) begin
         t = x; x = y; y = t;
      end
      if (y > z) begin
         t = y; y = z; z = t;
      end
      return {z, y, x};
   endfunction

   function automatic logic [W-1:0] med3(input logic [W-1:0] a,
                                         input logic [W-1:0] b,
                                         input logic [W-1:0] c);
      logic [W-1:0] lo;
      logic [W-1:0] hi;
      logic [W-1:0] m;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      m  = (hi < c) ? hi : c;
      return (lo > m) ? lo : m;
   endfunction

   rmf_pkg::window_type s1_ff;
   rmf_pkg::window_type s2_ff;
   rmf_pkg::window_type s2_in;
   logic [2:0][W-1:0]   s3_ff;
   logic [2:0][W-1:0]   s3_in;
   logic [W-1:0]        s4_ff;
   logic [W-1:0]        s4_in;

   // Sort each window row; low at column 0.
   always_comb begin
      for (int r = 0; r < S; r++) begin
         {s2_in[r*S+2], s2_in[r*S+1], s2_in[r*S]} =
            sort3(s1_ff[r*S], s1_ff[r*S+1], s1_ff[r*S+2]);
      end
   end

   // Median is med3 of (max of row lows, median of row mids, min of row highs).
   always_comb begin
      logic [W-1:0] m01;
      logic [W-1:0] n01;
      m01      = (s2_ff[0] > s2_ff[3]) ? s2_ff[0] : s2_ff[3];
      s3_in[0] = (m01 > s2_ff[6]) ? m01 : s2_ff[6];
      s3_in[1] = med3(s2_ff[1], s2_ff[4], s2_ff[7]);
      n01      = (s2_ff[2] < s2_ff[5]) ? s2_ff[2] : s2_ff[5];
      s3_in[2] = (n01 < s2_ff[8]) ? n01 : s2_ff[8];
   end

   assign s4_in = med3(s3_ff[0], s3_ff[1], s3_ff[2]);

   always_ff @(posedge clock) begin
      if (en.s1) begin
         s1_ff <= window_in;
      end
      if (en.s2) begin
         s2_ff <= s2_in;
      end
      if (en.s3) begin
         s3_ff <= s3_in;
      end
      if (en.s4) begin
         s4_ff <= s4_in;
      end
   end

   assign median_out = s4_ff;
endmodule
`default_nettype wire

### src/rgb_median_filter_3x3_unit.sv
// Top level of the RGB 3x3 median filter: window tap chain, counters,
// pipeline control and three median lanes. Depends on rmf_pkg,
// rmf_tap_cell, rmf_median_lane and assert_macros.svh.
//
//   channel   handshake           payload            direction
//   req       req_valid/stall     req_payload        in, one pixel
//   rsp       rsp_valid/stall     rsp_payload        out, one median set
//   csr       csr_valid/ready     csr_wdata[11:0]    in, image_width
//
// One request per clock while req_stall is low; a new pixel may enter every such cycle.
// A median passes through registers s1, s2, s3 and s4 after the request that completes its window.
// Four result slots (three pipeline stages plus the output register) fill
// under rsp_stall before req_stall rises.
// Synchronous reset clears counters and valid bits; image_width resets to 512.
`default_nettype none
`include "assert_macros.svh"
module rgb_median_filter_3x3_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire rmf_pkg::req_payload_type               req_payload,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output rmf_pkg::rsp_payload_type                    rsp_payload,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [rmf_pkg::COUNT_W-1:0]            csr_wdata
);
   localparam int S = rmf_pkg::WINDOW_SIDE;
   localparam int N = rmf_pkg::AREA;

   logic [rmf_pkg::COUNT_W-1:0] width_ff;
   logic [rmf_pkg::COUNT_W-1:0] width_in;
   logic [rmf_pkg::COUNT_W-1:0] column_ff;
   logic [rmf_pkg::COUNT_W-1:0] column_in;
   logic [rmf_pkg::COUNT_W-1:0] column_inc;
   logic [rmf_pkg::FILL_W-1:0]  fill_ff;
   logic [rmf_pkg::FILL_W-1:0]  fill_in;
   logic [rmf_pkg::FILL_W-1:0]  load_idx;
   logic [rmf_pkg::ROW_W-1:0]   shift_row;
   logic                        load_mode;
   logic                        accept;
   logic                        done;
   logic                        v1_ff, v2_ff, v3_ff, v4_ff;
   logic                        v1_in, v2_in, v3_in, v4_in;
   logic                        ready1, ready2, ready3, ready4;
   rmf_pkg::stage_en_type       stage_en;
   rmf_pkg::req_payload_type    tap_q    [N];
   rmf_pkg::req_payload_type    tap_nx   [N];
   rmf_pkg::window_type         win_red, win_green, win_blue;

   // Pipeline flow: a stage loads when it is empty or its successor moves.
   assign ready4    = !v4_ff || !rsp_stall;
   assign ready3    = !v3_ff || ready4;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_stall = !ready1;
   assign accept    = req_valid && ready1;
   assign csr_ready = 1'b1;

   assign load_mode = (column_ff == '0);
   assign load_idx  = (fill_ff >= rmf_pkg::FILL_W'(N - 1)) ?
                      rmf_pkg::FILL_W'(N - 1) : fill_ff;
   assign shift_row = (fill_ff >= rmf_pkg::FILL_W'(S - 1)) ?
                      rmf_pkg::ROW_W'(S - 1) : fill_ff[rmf_pkg::ROW_W-1:0];
   assign done      = load_mode ? (load_idx == rmf_pkg::FILL_W'(N - 1))
                                : (shift_row == rmf_pkg::ROW_W'(S - 1));
   assign column_inc = column_ff + 1'b1;

   always_comb begin
      width_in  = width_ff;
      column_in = column_ff;
      fill_in   = fill_ff;
      if (csr_valid && csr_ready) begin
         width_in = csr_wdata;
      end
      if (accept) begin
         if (done) begin
            fill_in   = '0;
            column_in = (column_inc >= width_ff) ? '0 : column_inc;
         end else if (load_mode) begin
            fill_in = load_idx + 1'b1;
         end else begin
            fill_in = {{(rmf_pkg::FILL_W - rmf_pkg::ROW_W){1'b0}}, shift_row} + 1'b1;
         end
      end
   end

   assign v1_in = ready1 ? (accept && done) : v1_ff;
   assign v2_in = ready2 ? v1_ff : v2_ff;
   assign v3_in = ready3 ? v2_ff : v3_ff;
   assign v4_in = ready4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rmf_pkg::WIDTH_RESET;
         column_ff <= '0;
         fill_ff   <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
      end else begin
         width_ff  <= width_in;
         column_ff <= column_in;
         fill_ff   <= fill_in;
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         v3_ff     <= v3_in;
         v4_ff     <= v4_in;
      end
   end

   // Window tap chain, row-major; each row's right end takes the new pixel.
   for (genvar k = 0; k < N; k++) begin : g_tap
      rmf_pkg::cell_ctl_type    ctl;
      rmf_pkg::req_payload_type nbr;
      assign ctl.load  = accept && load_mode && (load_idx == rmf_pkg::FILL_W'(k));
      assign ctl.shift = accept && !load_mode &&
                         (shift_row == rmf_pkg::ROW_W'(k / S));
      if ((k % S) == (S - 1)) begin : g_end
         assign nbr = req_payload;
      end else begin : g_mid
         assign nbr = tap_q[k+1];
      end
      rmf_tap_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .pixel_in    (req_payload),
         .neighbor_in (nbr),
         .tap_out     (tap_q[k]),
         .tap_next    (tap_nx[k])
      );
      assign win_red[k]   = tap_nx[k].pixel_red;
      assign win_green[k] = tap_nx[k].pixel_green;
      assign win_blue[k]  = tap_nx[k].pixel_blue;
   end

   assign stage_en.s1 = accept && done;
   assign stage_en.s2 = ready2;
   assign stage_en.s3 = ready3;
   assign stage_en.s4 = ready4;

   rmf_median_lane u_red (
      .clock      (clock),
      .en         (stage_en),
      .window_in  (win_red),
      .median_out (rsp_payload.median_red)
   );
   rmf_median_lane u_green (
      .clock      (clock),
      .en         (stage_en),
      .window_in  (win_green),
      .median_out (rsp_payload.median_green)
   );
   rmf_median_lane u_blue (
      .clock      (clock),
      .en         (stage_en),
      .window_in  (win_blue),
      .median_out (rsp_payload.median_blue)
   );

   assign rsp_valid = v4_ff;

   `RMF_ASSERT(a_fill_range, clock, reset, fill_ff <= rmf_pkg::FILL_W'(N - 1))
   `RMF_ASSERT(a_shift_fill, clock, reset, (column_ff == '0) || (fill_ff <= rmf_pkg::FILL_W'(S - 1)))
   `RMF_ASSERT_NEXT(a_capture, clock, reset, accept && done, v1_ff)
   `RMF_ASSERT(a_stall_full, clock, reset, !req_stall || (v1_ff && v2_ff && v3_ff && v4_ff))
endmodule
`default_nettype wire

### test/tb_top.sv
// Testbench for the RGB 3x3 median filter: directed rows, then random phases.
// Checks every median against a predictor kept in step with the requests.
// Depends on rmf_pkg and rgb_median_filter_3x3_unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 1350;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [11:0] WIDTH_AT_RESET = 12'd512;

   typedef logic [8:0][7:0] pix_window_type;

   // one directed row: either a width write or a pixel request
   typedef struct packed {
      bit                        width_write;
      bit                        typed;
      logic [11:0]               width_val;
      rmf_pkg::req_payload_type  pixel;
      rmf_pkg::rsp_payload_type  median;
   } step_row_type;

   localparam int ROW_COUNT = 26;
   localparam step_row_type SCRIPT [ROW_COUNT] = '{
      // nine black pixels fill the first window
      {1'b0, 1'b0, 12'd0, 24'h000000, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'h000000, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'h000000, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'h000000, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'h000000, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'h000000, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'h000000, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'h000000, 24'h000000},
      {1'b0, 1'b1, 12'd0, 24'h000000, 24'h000000},
      // one white column: six zeros stay, median is still zero
      {1'b0, 1'b0, 12'd0, 24'hFFFFFF, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'hFFFFFF, 24'h000000},
      {1'b0, 1'b1, 12'd0, 24'hFFFFFF, 24'h000000},
      // width drops below the current column: row ends at next output
      {1'b1, 1'b0, 12'd1, 24'h000000, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'hAA550F, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'h55AAF0, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'h0FF0A5, 24'h000000},
      // width zero: every output reloads all nine
      {1'b1, 1'b0, 12'd0, 24'h000000, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'hFF00FF, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'hFF00FF, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'hFF00FF, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'hFF00FF, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'hFF00FF, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'hFF00FF, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'hFF00FF, 24'h000000},
      {1'b0, 1'b0, 12'd0, 24'hFF00FF, 24'h000000},
      {1'b0, 1'b1, 12'd0, 24'hFF00FF, 24'hFF00FF}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rmf_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rmf_pkg::rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rmf_pkg::COUNT_W-1:0] csr_wdata = '0;

   // predictor state
   pix_window_type win_red = '0;
   pix_window_type win_green = '0;
   pix_window_type win_blue = '0;
   logic [11:0] column_now = '0;
   logic [3:0] fill_now = '0;
   logic [11:0] width_now = WIDTH_AT_RESET;

   rmf_pkg::rsp_payload_type pending_medians[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit stall_enable = 1'b1;
   int stall_hold = 0;

   rgb_median_filter_3x3_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // 5th smallest of nine: the value with at most four below it and at least
   // five at or below it
   function automatic logic [7:0] middle_value(input pix_window_type w);
      int below;
      int at_or_below;
      for (int i = 0; i < 9; i++) begin
         below = 0;
         at_or_below = 0;
         for (int j = 0; j < 9; j++) begin
            if (w[j] < w[i]) below++;
            if (w[j] <= w[i]) at_or_below++;
         end
         if (below <= 4 && at_or_below >= 5) return w[i];
      end
      return 8'h00;
   endfunction

   function automatic pix_window_type shift_row(input pix_window_type w, input int row,
                                                input logic [7:0] v);
      pix_window_type nw;
      nw = w;
      nw[row*3]     = w[row*3 + 1];
      nw[row*3 + 1] = w[row*3 + 2];
      nw[row*3 + 2] = v;
      return nw;
   endfunction

   task automatic filter_pixel(input rmf_pkg::req_payload_type px, output bit made,
                               output rmf_pkg::rsp_payload_type med);
      int slot;
      logic [11:0] nxt;
      made = 1'b0;
      med = '0;
      if (column_now == 0) begin
         slot = (fill_now >= 9) ? 8 : int'(fill_now);
         win_red[slot] = px.pixel_red;
         win_green[slot] = px.pixel_green;
         win_blue[slot] = px.pixel_blue;
         fill_now = 4'(slot + 1);
         made = (slot + 1 >= 9);
      end else begin
         slot = (fill_now >= 3) ? 2 : int'(fill_now);
         win_red = shift_row(win_red, slot, px.pixel_red);
         win_green = shift_row(win_green, slot, px.pixel_green);
         win_blue = shift_row(win_blue, slot, px.pixel_blue);
         fill_now = 4'(slot + 1);
         made = (slot + 1 >= 3);
      end
      if (made) begin
         med.median_red = middle_value(win_red);
         med.median_green = middle_value(win_green);
         med.median_blue = middle_value(win_blue);
         fill_now = '0;
         nxt = column_now + 12'd1;
         if (nxt >= width_now) nxt = '0;
         column_now = nxt;
      end
   endtask

   // drive one request at the current edge and hold it until accepted
   task automatic send_pixel(input rmf_pkg::req_payload_type px, input bit typed,
                             input rmf_pkg::rsp_payload_type typed_med);
      bit go;
      bit made;
      rmf_pkg::rsp_payload_type med;
      req_valid <= 1'b1;
      req_payload <= px;
      go = 1'b0;
      while (!go) begin
         @(negedge clock);
         go = (req_stall === 1'b0);
         @(posedge clock);
      end
      filter_pixel(px, made, med);
      if (made) pending_medians.push_back(typed ? typed_med : med);
   endtask

   task automatic idle_sender(input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [11:0] w);
      bit go;
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= w;
      go = 1'b0;
      while (!go) begin
         @(negedge clock);
         go = (csr_ready === 1'b1);
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      width_now = w;
   endtask

   function automatic int pick_gap(input bit gaps_on);
      int pick;
      if (!gaps_on) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] pick_level(input int mode);
      unique case (mode)
         1: return 8'($urandom_range(0, 3));
         2: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [11:0] pick_width();
      unique case ($urandom_range(0, 9))
         0: return 12'd0;
         1: return 12'd1;
         2: return 12'd2;
         3: return 12'd3;
         4: return 12'd4095;
         5: return WIDTH_AT_RESET;
         6: return 12'($urandom_range(4, 40));
         7: return 12'($urandom_range(0, 4095));
         default: return 12'($urandom_range(2, 8));
      endcase
   endfunction

   // receiver back-pressure: short bursts mostly, now and then a long one
   always @(posedge clock) begin : rsp_stall_gen
      int pick;
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else if (!stall_enable) begin
         rsp_stall <= 1'b0;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            rsp_stall <= 1'b0;
            stall_hold <= $urandom_range(0, 4);
         end else if (pick < 95) begin
            rsp_stall <= 1'b1;
            stall_hold <= $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_hold <= $urandom_range(10, 40);
         end
      end
   end

   // outputs are stable at the falling edge; a median seen here is taken
   // at the next rising edge
   always @(negedge clock) begin : median_check
      rmf_pkg::rsp_payload_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_medians.size() == 0) begin
            $error("median with none pending: %h", rsp_payload);
            mismatch_count++;
         end else begin
            want = pending_medians.pop_front();
            if (rsp_payload.median_red !== want.median_red) begin
               $error("median_red: expected %0d, actual %0d",
                      want.median_red, rsp_payload.median_red);
               mismatch_count++;
            end
            if (rsp_payload.median_green !== want.median_green) begin
               $error("median_green: expected %0d, actual %0d",
                      want.median_green, rsp_payload.median_green);
               mismatch_count++;
            end
            if (rsp_payload.median_blue !== want.median_blue) begin
               $error("median_blue: expected %0d, actual %0d",
                      want.median_blue, rsp_payload.median_blue);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : main_flow
      int random_sent;
      int phase_len;
      int level_mode;
      bit gaps_on;
      rmf_pkg::req_payload_type px;
      random_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < ROW_COUNT; i++) begin
         if (SCRIPT[i].width_write) begin
            write_width(SCRIPT[i].width_val);
         end else begin
            send_pixel(SCRIPT[i].pixel, SCRIPT[i].typed, SCRIPT[i].median);
            idle_sender(pick_gap(1'b1));
         end
      end

      while (random_sent < RANDOM_ITEMS) begin
         write_width(pick_width());
         phase_len = $urandom_range(20, 80);
         level_mode = $urandom_range(0, 3);
         gaps_on = ($urandom_range(0, 3) != 0);
         stall_enable = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < phase_len; k++) begin
            px.pixel_red = pick_level(level_mode);
            px.pixel_green = pick_level(level_mode);
            px.pixel_blue = pick_level(level_mode);
            send_pixel(px, 1'b0, '0);
            random_sent++;
            // hold off until the pipe has drained, now and then
            if ($urandom_range(0, 199) == 0) wait_drained();
            else idle_sender(pick_gap(gaps_on));
         end
      end

      stall_enable = 1'b1;
      wait_drained();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && pending_medians.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire
